// ===== sv/slp_pkg.sv =====
// Package for the static loop partition block.
// Holds the word width, the team size bounds and the item record carried
// down the pipeline. Used by static_loop_partition.sv.
package slp_pkg;

	localparam int WORD_BITS = 32;
	localparam int TEAM_W    = 11;
	localparam int TID_W     = 10;
	localparam int CHUNK_W   = 31;

	localparam logic [TEAM_W-1:0] TEAM_RESET = 11'd8;
	localparam logic [TEAM_W-1:0] TEAM_MAX   = 11'd1024;

	typedef enum logic [1:0] {
		KIND_CHUNKED  = 2'd0,
		KIND_BALANCED = 2'd1,
		KIND_PASS     = 2'd2,
		KIND_PASS_ALT = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [WORD_BITS-1:0]  lo;
		logic [WORD_BITS-1:0]  up;
		logic [WORD_BITS-1:0]  step;
		logic [CHUNK_W-1:0]    chunk;
		logic [TID_W-1:0]      tid;
		logic [TEAM_W-1:0]     nth;
		logic                  err;
		logic                  dneg;
		logic [WORD_BITS-1:0]  dabs;
		logic [WORD_BITS-1:0]  sabs;
		logic [WORD_BITS-1:0]  trip;
		logic                  pos;
		logic [WORD_BITS-1:0]  span;
		logic [WORD_BITS-1:0]  stride;
		logic [WORD_BITS-1:0]  first;
		logic [WORD_BITS-1:0]  lastc;
		logic [WORD_BITS-1:0]  q;
		logic [WORD_BITS-1:0]  k;
		logic [TEAM_W-1:0]     kmod;
		logic [WORD_BITS-1:0]  qn;
		logic [WORD_BITS-1:0]  r;
		logic                  lt;
		logic [WORD_BITS-1:0]  cnt;
		logic [WORD_BITS-1:0]  m;
		logic [WORD_BITS-1:0]  base;
		logic [WORD_BITS-1:0]  off;
		logic [WORD_BITS-1:0]  firstb;
		logic [WORD_BITS-1:0]  cs;
	} item_t;

endpackage

// ===== sv/slp_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Carries a sideband word alongside the operands; stalls on a shared enable.
// Stand-alone; instantiated by static_loop_partition.sv.
module slp_div #(
	parameter int NUM_W  = 32,
	parameter int DEN_W  = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [NUM_W-1:0]  quot,
	output logic [DEN_W-1:0]  rem,
	output logic [SIDE_W-1:0] side_out
);

	logic [NUM_W-1:0]  num_s  [NUM_W+1];
	logic [DEN_W-1:0]  rem_s  [NUM_W+1];
	logic [DEN_W-1:0]  den_s  [NUM_W+1];
	logic [SIDE_W-1:0] side_s [NUM_W+1];
	logic              vld_s  [NUM_W+1];

	assign num_s[0]  = num;
	assign rem_s[0]  = '0;
	assign den_s[0]  = den;
	assign side_s[0] = side_in;
	assign vld_s[0]  = in_valid;

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W:0]   t;
		logic [DEN_W:0]   d;
		logic             ge;
		logic [DEN_W-1:0] nrem;

		always_comb begin
			t    = {rem_s[i], num_s[i][NUM_W-1]};
			d    = t - {1'b0, den_s[i]};
			ge   = t >= {1'b0, den_s[i]};
			nrem = ge ? d[DEN_W-1:0] : t[DEN_W-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[i+1]  <= {num_s[i][NUM_W-2:0], ge};
				rem_s[i+1]  <= nrem;
				den_s[i+1]  <= den_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = vld_s[NUM_W];
	assign quot      = num_s[NUM_W];
	assign rem       = rem_s[NUM_W];
	assign side_out  = side_s[NUM_W];

endmodule

// ===== sv/static_loop_partition.sv =====
// Static loop partition: one thread's share of a counted loop per item.
// The pipeline is an input register, three ranks of 32-stage dividers
// (trip count, then chunk index beside balanced quotient, then chunk owner),
// ten arithmetic stages and the output register. Throughput one item per
// cycle; the whole pipeline holds while the output register is full and not
// taken. Reset clears all valid bits and sets the team size to 8.
module static_loop_partition
	import slp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          team_threads_we,
	input  logic [10:0]   team_threads_wdata,
	input  logic          s_tvalid,
	output logic          s_tready,
	// lower_bound[31:0], upper_bound[63:32], step[95:64], chunk_len[126:96],
	// thread_index[136:127], zero fill
	input  logic [143:0]  s_tdata,
	// kind[1:0]
	input  logic [1:0]    s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// first_iter[31:0], last_iter[63:32], stride_out[95:64], is_last_chunk[96],
	// zero fill
	output logic [103:0]  m_tdata,
	// error[0]
	output logic          m_tuser
);

	localparam int W       = WORD_BITS;
	localparam int ITEM_W  = $bits(item_t);

	logic [TEAM_W-1:0] team_q;
	logic              en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			team_q <= TEAM_RESET;
		end else if (team_threads_we) begin
			team_q <= team_threads_wdata;
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: capture, clamp team size, operand magnitudes
	item_t n1, it_s1;
	logic  v_s1;
	logic [W-1:0] diff1;

	always_comb begin
		n1       = '0;
		n1.kind  = kind_t'(s_tuser);
		n1.lo    = s_tdata[31:0];
		n1.up    = s_tdata[63:32];
		n1.step  = s_tdata[95:64];
		n1.chunk = s_tdata[126:96];
		n1.tid   = s_tdata[136:127];
		if (team_q == '0) begin
			n1.nth = TEAM_W'(1);
		end else if (team_q > TEAM_MAX) begin
			n1.nth = TEAM_MAX;
		end else begin
			n1.nth = team_q;
		end
		n1.err   = (n1.step == '0) || (n1.kind == KIND_CHUNKED && n1.chunk == '0);
		diff1    = n1.up - n1.lo;
		n1.dneg  = diff1[W-1] ^ n1.step[W-1];
		n1.dabs  = diff1[W-1] ? -diff1 : diff1;
		n1.sabs  = n1.step[W-1] ? -n1.step : n1.step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= n1;
		end
	end

	// trip count division
	logic              d1_vld;
	logic [W-1:0]      d1_quot;
	logic [W-1:0]      d1_rem;
	logic [ITEM_W-1:0] d1_side;

	slp_div #(.NUM_W(W), .DEN_W(W), .SIDE_W(ITEM_W)) u_div_trip (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .num(it_s1.dabs), .den(it_s1.sabs), .side_in(it_s1),
		.out_valid(d1_vld), .quot(d1_quot), .rem(d1_rem), .side_out(d1_side)
	);

	// stage 2: trip count and chunk span
	item_t n2, it_s2;
	logic  v_s2;

	always_comb begin
		n2      = item_t'(d1_side);
		n2.trip = (n2.dneg ? -d1_quot : d1_quot) + W'(1) + (W'(0) & d1_rem);
		n2.pos  = (n2.trip != '0) && !n2.trip[W-1];
		n2.span = n2.step * {1'b0, n2.chunk};
	end

	// stage 3: chunked stride
	item_t n3, it_s3;
	logic  v_s3;

	always_comb begin
		n3        = it_s2;
		n3.stride = it_s2.span * {{(W-TEAM_W){1'b0}}, it_s2.nth};
	end

	// stage 4: chunked first iteration
	item_t n4, it_s4;
	logic  v_s4;

	always_comb begin
		n4       = it_s3;
		n4.first = it_s3.lo + it_s3.span * {{(W-TID_W){1'b0}}, it_s3.tid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s2 <= d1_vld;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s2 <= n2;
			it_s3 <= n3;
			it_s4 <= n4;
		end
	end

	// chunk index and balanced quotient, side by side
	logic [W-1:0]      trip_m1;
	logic [W-1:0]      trip_abs;
	logic              d2_vld;
	logic [W-1:0]      d2_quot;
	logic [CHUNK_W-1:0] d2_rem;
	logic [ITEM_W-1:0] d2_side;
	logic              d3_vld;
	logic [W-1:0]      d3_quot;
	logic [TEAM_W-1:0] d3_rem;
	logic              d3_side;

	assign trip_m1  = it_s4.trip - W'(1);
	assign trip_abs = it_s4.trip[W-1] ? -it_s4.trip : it_s4.trip;

	slp_div #(.NUM_W(W), .DEN_W(CHUNK_W), .SIDE_W(ITEM_W)) u_div_chunk (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s4), .num(trip_m1), .den(it_s4.chunk), .side_in(it_s4),
		.out_valid(d2_vld), .quot(d2_quot), .rem(d2_rem), .side_out(d2_side)
	);

	slp_div #(.NUM_W(W), .DEN_W(TEAM_W), .SIDE_W(1)) u_div_bal (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s4), .num(trip_abs), .den(it_s4.nth), .side_in(it_s4.trip[W-1]),
		.out_valid(d3_vld), .quot(d3_quot), .rem(d3_rem), .side_out(d3_side)
	);

	// stage 5: chunk index and signed quotient
	item_t n5, it_s5;
	logic  v_s5;

	always_comb begin
		n5   = item_t'(d2_side);
		n5.k = d2_quot + (W'(0) & {d2_rem, 1'b0});
		n5.q = (d3_side ? -d3_quot : d3_quot)
			+ (W'(0) & {{(W-TEAM_W-1){1'b0}}, d3_rem, d3_vld});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s5 <= n5;
		end
	end

	// owner of the final chunk
	logic              d4_vld;
	logic [W-1:0]      d4_quot;
	logic [TEAM_W-1:0] d4_rem;
	logic [ITEM_W-1:0] d4_side;

	slp_div #(.NUM_W(W), .DEN_W(TEAM_W), .SIDE_W(ITEM_W)) u_div_own (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s5), .num(it_s5.k), .den(it_s5.nth), .side_in(it_s5),
		.out_valid(d4_vld), .quot(d4_quot), .rem(d4_rem), .side_out(d4_side)
	);

	// stages 6 to 11: final chunk owner, chunked last iteration, balanced share
	item_t n6, it_s6, n7, it_s7, n8, it_s8, n9, it_s9, n10, it_s10, n11, it_s11;
	logic  v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic [W-1:0] tid_w7, tid_w8;

	always_comb begin
		n6       = item_t'(d4_side);
		n6.kmod  = d4_rem + (TEAM_W'(0) & d4_quot[TEAM_W-1:0]);
		n6.qn    = n6.q * {{(W-TEAM_W){1'b0}}, n6.nth};
		n6.lastc = n6.first + n6.span - n6.step;
	end

	always_comb begin
		n7     = it_s6;
		tid_w7 = {{(W-TID_W){1'b0}}, it_s6.tid};
		n7.r   = it_s6.trip - it_s6.qn;
		n7.lt  = $signed(tid_w7) < $signed(n7.r);
		n7.cnt = n7.lt ? it_s6.q + W'(1) : it_s6.q;
	end

	always_comb begin
		n8     = it_s7;
		tid_w8 = {{(W-TID_W){1'b0}}, it_s7.tid};
		n8.m   = tid_w8 * it_s7.cnt;
	end

	always_comb begin
		n9      = it_s8;
		n9.base = it_s8.lt ? it_s8.m : it_s8.m + it_s8.r;
	end

	always_comb begin
		n10     = it_s9;
		n10.off = it_s9.base * it_s9.step;
	end

	always_comb begin
		n11        = it_s10;
		n11.firstb = it_s10.lo + it_s10.off;
		n11.cs     = it_s10.cnt * it_s10.step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s6  <= d4_vld;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s6  <= n6;
			it_s7  <= n7;
			it_s8  <= n8;
			it_s9  <= n9;
			it_s10 <= n10;
			it_s11 <= n11;
		end
	end

	// output register: select by kind
	logic [W-1:0] o_first, o_last, o_stride, own_b;
	logic         o_islast;

	always_comb begin
		o_first  = it_s11.lo;
		o_last   = it_s11.up;
		o_stride = '0;
		o_islast = 1'b0;
		own_b    = (($signed(it_s11.trip) < $signed({{(W-TEAM_W){1'b0}}, it_s11.nth}))
			? it_s11.trip : {{(W-TEAM_W){1'b0}}, it_s11.nth}) - W'(1);
		if (!it_s11.err) begin
			case (it_s11.kind)
				KIND_CHUNKED: begin
					o_first  = it_s11.first;
					o_last   = it_s11.lastc;
					o_stride = it_s11.stride;
					o_islast = it_s11.pos && (it_s11.kmod == {1'b0, it_s11.tid});
				end
				KIND_BALANCED: begin
					o_first  = it_s11.firstb;
					o_last   = it_s11.firstb + it_s11.cs - it_s11.step;
					o_stride = it_s11.trip;
					o_islast = it_s11.pos && (own_b == {{(W-TID_W){1'b0}}, it_s11.tid});
				end
				default: begin
					o_first  = it_s11.lo;
					o_last   = it_s11.up;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {7'd0, o_islast, o_stride, o_last, o_first};
			m_tuser <= it_s11.err;
		end
	end

endmodule

// ===== tb/tb_static_loop_partition.sv =====
// Testbench for static_loop_partition: directed and random loop requests
// checked against a behavioral partition predictor. Depends on slp_pkg.
`timescale 1ns / 100ps

module tb_static_loop_partition
	import slp_pkg::*;
;

	localparam int LATENCY   = 108;
	localparam int N_RANDOM  = 1250;
	localparam int MAX_CYC   = 400000;

	typedef struct {
		kind_t       kind;
		logic [31:0] lo;
		logic [31:0] up;
		logic [31:0] step;
		logic [30:0] chunk;
		logic [9:0]  tid;
	} request_t;

	typedef struct {
		logic [31:0] first;
		logic [31:0] last;
		logic [31:0] stride;
		logic        islast;
		logic        err;
	} share_t;

	typedef struct {
		request_t req;
		bit       typed;
		share_t   res;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         team_threads_we;
	logic [10:0]  team_threads_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;
	logic         m_tuser;

	static_loop_partition uut (
		.clk(clk), .arst_n(arst_n),
		.team_threads_we(team_threads_we), .team_threads_wdata(team_threads_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	share_t      expected_shares[$];
	logic [10:0] team_size;
	int          mismatches;
	int          results_seen;
	int          cycles;
	bit          sink_calm;
	bit          src_calm;

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
		logic [31:0] aa, ab, q;
		aa = a[31] ? -a : a;
		ab = b[31] ? -b : b;
		q = aa / ab;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	function automatic logic [31:0] smod(logic [31:0] a, logic [31:0] b);
		logic [31:0] aa, ab, r;
		aa = a[31] ? -a : a;
		ab = b[31] ? -b : b;
		r = aa % ab;
		return a[31] ? -r : r;
	endfunction

	function automatic share_t partition_share(request_t rq, logic [10:0] team);
		share_t      s;
		logic [31:0] nth, trip, span, k, q, r, cnt, m;
		bit          positive;
		nth = (team == 0) ? 32'd1 : (team > TEAM_MAX) ? 32'd1024 : {21'd0, team};
		s.first = rq.lo;
		s.last = rq.up;
		s.stride = 0;
		s.islast = 0;
		s.err = 0;
		if (rq.step == 0 || (rq.kind == KIND_CHUNKED && rq.chunk == 0)) begin
			s.err = 1;
		end else if (rq.kind == KIND_CHUNKED || rq.kind == KIND_BALANCED) begin
			trip = sdiv(rq.up - rq.lo, rq.step) + 32'd1;
			positive = (trip != 0) && !trip[31];
			if (rq.kind == KIND_CHUNKED) begin
				span = rq.step * {1'b0, rq.chunk};
				s.stride = span * nth;
				s.first = rq.lo + span * {22'd0, rq.tid};
				s.last = s.first + span - rq.step;
				if (positive) begin
					k = sdiv(trip - 32'd1, {1'b0, rq.chunk});
					s.islast = (smod(k, nth) == {22'd0, rq.tid});
				end
			end else begin
				q = sdiv(trip, nth);
				r = trip - q * nth;
				if ($signed({22'd0, rq.tid}) < $signed(r)) begin
					cnt = q + 32'd1;
					s.first = rq.lo + {22'd0, rq.tid} * cnt * rq.step;
				end else begin
					cnt = q;
					s.first = rq.lo + ({22'd0, rq.tid} * q + r) * rq.step;
				end
				s.last = s.first + cnt * rq.step - rq.step;
				s.stride = trip;
				if (positive) begin
					m = ($signed(trip) < $signed(nth)) ? trip : nth;
					s.islast = ({22'd0, rq.tid} == m - 32'd1);
				end
			end
		end
		return s;
	endfunction

	task automatic write_team(logic [10:0] v);
		@(negedge clk);
		team_threads_we <= 1'b1;
		team_threads_wdata <= v;
		@(negedge clk);
		team_threads_we <= 1'b0;
		team_size = v;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_shares.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic send_request(request_t rq, bit typed, share_t typed_res);
		while (!src_calm && $urandom_range(99) < 31) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= rq.kind;
		s_tdata <= {7'd0, rq.tid, rq.chunk, rq.step, rq.up, rq.lo};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_shares.push_back(typed ? typed_res : partition_share(rq, team_size));
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h8000_0000 + $urandom_range(3);
			1: return 32'h7FFF_FFFF - $urandom_range(3);
			2: return $urandom_range(40) - 20;
			3: return $urandom_range(2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic request_t rand_request(logic [10:0] team);
		request_t rq;
		rq.kind = kind_t'($urandom_range(9) < 4 ? 0 : $urandom_range(9) < 7 ? 1 : $urandom_range(3));
		rq.lo = rand_word();
		if ($urandom_range(3) != 0) begin
			rq.step = $urandom_range(9) == 0 ? 32'd0 : $urandom_range(7) + 1;
			if ($urandom_range(2) == 0) rq.step = -rq.step;
			rq.up = rq.lo + rq.step * ($urandom_range(3000) - 100);
		end else begin
			rq.up = rand_word();
			rq.step = rand_word();
		end
		case ($urandom_range(3))
			0: rq.chunk = $urandom_range(1) ? 31'h7FFF_FFFF : 31'd0;
			1: rq.chunk = $urandom;
			default: rq.chunk = $urandom_range(16);
		endcase
		rq.tid = $urandom_range(3) == 0 ? 10'($urandom) : 10'($urandom_range(team));
		return rq;
	endfunction

	// output side: random stall, compare against oldest expectation
	always @(negedge clk) begin
		if (arst_n) m_tready <= sink_calm ? 1'b1 : ($urandom_range(99) >= 31);
	end

	always @(posedge clk) begin
		share_t e;
		cycles <= cycles + 1;
		if (m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (expected_shares.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10) $display("unexpected result %h", m_tdata);
			end else begin
				e = expected_shares.pop_front();
				if (m_tdata[31:0] !== e.first || m_tdata[63:32] !== e.last ||
				    m_tdata[95:64] !== e.stride || m_tdata[96] !== e.islast ||
				    m_tuser !== e.err) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("mismatch exp %h %h %h %b %b got %h %h %h %b %b",
							e.first, e.last, e.stride, e.islast, e.err,
							m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
							m_tdata[96], m_tuser);
				end
			end
		end
		if (cycles > MAX_CYC) begin
			$display("timeout");
			$display("[static_loop_partition] ERROR");
			$finish;
		end
	end

	row_t        rows[$];
	int          directed_cnt;
	logic [10:0] teams[6] = '{11'd8, 11'd1, 11'd1024, 11'd0, 11'd2047, 11'd3};

	function automatic row_t mk(kind_t kd, logic [31:0] lo, logic [31:0] up,
			logic [31:0] st, logic [30:0] ch, logic [9:0] tid, bit typed,
			logic [31:0] f, logic [31:0] l, logic [31:0] sd, bit il, bit er);
		row_t r;
		r.req = '{kd, lo, up, st, ch, tid};
		r.typed = typed;
		r.res = '{f, l, sd, il, er};
		return r;
	endfunction

	initial begin
		mismatches = 0;
		results_seen = 0;
		cycles = 0;
		sink_calm = 0;
		src_calm = 0;
		team_size = TEAM_RESET;
		arst_n = 1'b0;
		team_threads_we = 1'b0;
		team_threads_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_CHUNKED;
		m_tready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		rows.push_back(mk(KIND_CHUNKED, 0, 99, 1, 0, 0, 1, 0, 99, 0, 0, 1));
		rows.push_back(mk(KIND_BALANCED, 5, 9, 0, 4, 0, 1, 5, 9, 0, 0, 1));
		rows.push_back(mk(KIND_PASS, 3, 7, 2, 0, 1, 1, 3, 7, 0, 0, 0));
		rows.push_back(mk(KIND_PASS_ALT, 32'h8000_0000, 32'h7FFF_FFFF, 0, 5, 1023,
			1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 1));
		rows.push_back(mk(KIND_CHUNKED, 0, 99, 1, 4, 0, 1, 0, 3, 32, 1, 0));
		rows.push_back(mk(KIND_CHUNKED, 0, 99, 1, 4, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(KIND_CHUNKED, 0, 99, 1, 4, 7, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(KIND_BALANCED, 0, 99, 1, 1, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(KIND_BALANCED, 0, 99, 1, 1, 3, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(KIND_BALANCED, 0, 99, 1, 1, 7, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(KIND_BALANCED, 0, 4, 1, 1, 4, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(KIND_BALANCED, 10, 0, 1, 1, 2, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(KIND_CHUNKED, 10, 0, 1, 3, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(KIND_CHUNKED, 100, 0, -3, 2, 900, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(KIND_BALANCED, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			1, 5, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(KIND_BALANCED, 32'h8000_0000, 0, 32'hFFFF_FFFF, 1, 1, 0,
			0, 0, 0, 0, 0));
		rows.push_back(mk(KIND_CHUNKED, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			31'h7FFF_FFFF, 1023, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(KIND_CHUNKED, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			31'h7FFF_FFFF, 512, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(KIND_BALANCED, 0, 32'hFFFF_FFFF, 1, 1, 1023, 0,
			0, 0, 0, 0, 0));

		// directed rows use reset team size with no idling on either side
		sink_calm = 1;
		src_calm = 1;
		foreach (rows[i]) begin
			send_request(rows[i].req, rows[i].typed, rows[i].res);
			directed_cnt++;
		end
		drain_results();
		sink_calm = 0;
		src_calm = 0;

		for (int ph = 0; ph < 6; ph++) begin
			write_team(teams[ph]);
			for (int i = 0; i < N_RANDOM / 6; i++) begin
				if (ph == 2 && i >= 50 && i < 150) begin
					src_calm = 1;
					sink_calm = 1;
				end else begin
					src_calm = 0;
					sink_calm = 0;
				end
				if (ph == 1 && i == 100) drain_results();
				send_request(rand_request(teams[ph]), 0, '{0, 0, 0, 0, 0});
			end
			drain_results();
		end
		write_team($urandom_range(1024, 1));
		for (int i = 0; i < 40; i++) send_request(rand_request(team_size), 0, '{0, 0, 0, 0, 0});
		drain_results();

		$display("covered %0d directed and %0d random requests, %0d results checked,",
			directed_cnt, N_RANDOM / 6 * 6 + 40, results_seen);
		$display("team sizes 0, 1, 3, 8, 1024, 2047 and one random size");
		if (mismatches == 0 && expected_shares.size() == 0) begin
			$display("[static_loop_partition] OK");
		end else begin
			$display("[static_loop_partition] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/slp_pkg.sv
sv/slp_div.sv
sv/static_loop_partition.sv
tb/tb_static_loop_partition.sv
